[design/fbsg_pkg.sv]
// Package with the item types, constants and helpers of the FAT boot sector geometry checker.
`timescale 1ns / 1ps
`default_nettype none
package fbsg_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam logic [15:0] SECTOR_MAGIC = 16'haa55;
  localparam logic [31:0] FAT16_MIN_CLUSTERS = 32'd4085;
  localparam int MIRROR_BIT = 7;
  localparam int DIR_ENTRY_SHIFT = 5;

  localparam logic [1:0] FAT_TYPE_12 = 2'd0;
  localparam logic [1:0] FAT_TYPE_16 = 2'd1;
  localparam logic [1:0] FAT_TYPE_32 = 2'd2;

  localparam logic REG_BLK_LOG2 = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [3:0] BLK_LOG2_RESET = 4'd9;

  typedef struct packed {
    logic [15:0] signature;
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] root_entry_count;
    logic [15:0] total_sectors_short;
    logic [15:0] fat_sectors_short;
    logic [31:0] total_sectors_long;
    logic [31:0] fat_sectors_long;
    logic [15:0] mirror_flags;
    logic [31:0] root_start_cluster;
  } sector_t;

  typedef struct packed {
    logic        valid_res;
    logic [1:0]  fat_type;
    logic [47:0] fat_byte_offset;
    logic [47:0] root_dir_blk;
    logic [21:0] root_bytes;
    logic [47:0] data_start_blk;
    logic [3:0]  clus_blk_log2;
    logic [12:0] cluster_bytes;
    logic [31:0] data_cluster_count;
    logic [31:0] root_clus;
  } result_t;

  typedef struct packed {
    logic [3:0]  blk_log2;
    logic [47:0] block_count;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic        fat32;
    logic [31:0] sectors;
    logic [3:0]  sector_shift;
    logic [2:0]  spc_shift;
    logic [4:0]  cluster_shift;
    logic [40:0] root_off;
    logic [21:0] root_secs;
    logic [36:0] fat_off;
    logic [31:0] root_clus;
  } check_t;

  function automatic logic [3:0] low_bit16(input logic [15:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) n = 4'(i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[design/fbsg_cfg.sv]
// Register file holding the device block shift and block count.
`timescale 1ns / 1ps
`default_nettype none
module fbsg_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  output fbsg_pkg::cfg_t          cfg
);

  logic [3:0]  blk_log2;
  logic [47:0] block_count;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_log2 <= fbsg_pkg::BLK_LOG2_RESET;
      block_count <= '0;
    end else if (wr) begin
      case (paddr[3])
        fbsg_pkg::REG_BLK_LOG2: blk_log2 <= pwdata[3:0];
        fbsg_pkg::REG_BLOCK_COUNT: block_count <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      fbsg_pkg::REG_BLK_LOG2: prdata = {60'd0, blk_log2};
      fbsg_pkg::REG_BLOCK_COUNT: prdata = {16'd0, block_count};
      default: prdata = '0;
    endcase
  end

  assign cfg.blk_log2 = blk_log2;
  assign cfg.block_count = block_count;

endmodule
`default_nettype wire

[design/fbsg_check.sv]
// First two pipeline stages: field checks, FAT size products, region offsets and the device size check.
`timescale 1ns / 1ps
`default_nettype none
module fbsg_check (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire fbsg_pkg::sector_t    sector,
  input  wire fbsg_pkg::cfg_t       cfg,
  output logic                      out_valid,
  output fbsg_pkg::check_t          chk
);

  // Stage one.
  logic        v1;
  logic        ok1;
  logic        fat32_1;
  logic [31:0] sectors1;
  logic [3:0]  a1;
  logic [2:0]  b1;
  logic [4:0]  csz1;
  logic [15:0] rsv1;
  logic [15:0] rent1;
  logic [15:0] bps1;
  logic [39:0] fat_prod1;
  logic [35:0] idx_prod1;
  logic        mirror_on1;
  logic [31:0] rclus1;

  logic [16:0] bsize;
  logic        fat32;
  logic [31:0] sectors;
  logic [31:0] fat_len;
  logic [3:0]  a;
  logic [2:0]  b;
  logic [7:0]  lb_spc;
  logic [4:0]  csz;
  logic        bad;
  logic        mirror_on;

  always_comb begin
    bsize = 17'd1 << cfg.blk_log2;
    fat32 = (sector.fat_sectors_short == '0);
    sectors = (sector.total_sectors_short != '0) ?
              {16'd0, sector.total_sectors_short} : sector.total_sectors_long;
    fat_len = fat32 ? sector.fat_sectors_long : {16'd0, sector.fat_sectors_short};
    a = fbsg_pkg::low_bit16(sector.bytes_per_sector);
    lb_spc = 8'(fbsg_pkg::low_bit16({8'd0, sector.sectors_per_cluster}));
    b = lb_spc[2:0];
    csz = {1'b0, a} + {2'b00, b};
    mirror_on = fat32 && sector.mirror_flags[fbsg_pkg::MIRROR_BIT];
    bad = (sector.signature != fbsg_pkg::SECTOR_MAGIC) ||
          (sector.bytes_per_sector == '0) || (sector.sectors_per_cluster == '0) ||
          (sector.reserved_sectors == '0) || (sector.fat_copies == '0) ||
          ({1'b0, sector.bytes_per_sector} < bsize) ||
          ((sector.bytes_per_sector & (sector.bytes_per_sector - 16'd1)) != '0) ||
          ((sector.sectors_per_cluster & (sector.sectors_per_cluster - 8'd1)) != '0) ||
          ((32'd1 << csz) > 32'(fbsg_pkg::PAGE_BYTES)) ||
          (sectors == '0) || (fat_len == '0) ||
          (mirror_on && ({4'd0, sector.mirror_flags[3:0]} >= sector.fat_copies));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ok1        <= !bad;
    fat32_1    <= fat32;
    sectors1   <= sectors;
    a1         <= a;
    b1         <= b;
    csz1       <= csz;
    rsv1       <= sector.reserved_sectors;
    rent1      <= sector.root_entry_count;
    bps1       <= sector.bytes_per_sector;
    fat_prod1  <= {32'd0, sector.fat_copies} * {8'd0, fat_len};
    idx_prod1  <= {32'd0, sector.mirror_flags[3:0]} * {4'd0, fat_len};
    mirror_on1 <= mirror_on;
    rclus1     <= fat32 ? sector.root_start_cluster : '0;
  end

  // Stage two.
  logic [15:0] bmask;
  logic [47:0] vol_sum;
  logic [47:0] blocks;
  logic [21:0] dir_sum;
  logic [21:0] root_secs;
  fbsg_pkg::check_t chk_next;

  always_comb begin
    bmask = 16'((17'd1 << cfg.blk_log2) - 17'd1);
    vol_sum = (48'(sectors1) << a1) + {32'd0, bmask} - 48'd1;
    blocks = vol_sum >> cfg.blk_log2;
    dir_sum = (22'(rent1) << fbsg_pkg::DIR_ENTRY_SHIFT) + {6'd0, bps1} - 22'd1;
    root_secs = dir_sum >> a1;
    chk_next.ok = ok1 && (blocks <= cfg.block_count);
    chk_next.fat32 = fat32_1;
    chk_next.sectors = sectors1;
    chk_next.sector_shift = a1;
    chk_next.spc_shift = b1;
    chk_next.cluster_shift = csz1;
    chk_next.root_off = {25'd0, rsv1} + {1'b0, fat_prod1};
    chk_next.root_secs = root_secs;
    chk_next.fat_off = {21'd0, rsv1} + (mirror_on1 ? {1'b0, idx_prod1} : 37'd0);
    chk_next.root_clus = rclus1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    chk <= chk_next;
  end

endmodule
`default_nettype wire

[design/fbsg_place.sv]
// Last two pipeline stages: data area check, cluster count and result formatting.
`timescale 1ns / 1ps
`default_nettype none
module fbsg_place (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire fbsg_pkg::check_t     chk,
  input  wire fbsg_pkg::cfg_t       cfg,
  output logic                      done,
  output fbsg_pkg::result_t         result
);

  // Stage three.
  logic        v3;
  logic        ok3;
  logic        fat32_3;
  logic [31:0] clusters3;
  logic [41:0] data_off3;
  logic [40:0] root_off3;
  logic [21:0] root_secs3;
  logic [36:0] fat_off3;
  logic [3:0]  a3;
  logic [4:0]  csz3;
  logic [31:0] rclus3;

  logic [41:0] data_off;
  logic [31:0] free_secs;
  logic        bad3;

  always_comb begin
    data_off = {1'b0, chk.root_off} + {20'd0, chk.root_secs};
    free_secs = chk.sectors - data_off[31:0];
    bad3 = (chk.fat32 && (chk.root_secs != '0)) || (data_off >= {10'd0, chk.sectors});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ok3        <= chk.ok && !bad3;
    fat32_3    <= chk.fat32;
    clusters3  <= free_secs >> chk.spc_shift;
    data_off3  <= data_off;
    root_off3  <= chk.root_off;
    root_secs3 <= chk.root_secs;
    fat_off3   <= chk.fat_off;
    a3         <= chk.sector_shift;
    csz3       <= chk.cluster_shift;
    rclus3     <= chk.root_clus;
  end

  // Stage four.
  logic [3:0]  d;
  logic [63:0] fat_bytes;
  logic [63:0] root_blk;
  logic [63:0] data_blk;
  logic [43:0] dir_bytes;
  logic [23:0] csize;
  logic [4:0]  cbs;
  fbsg_pkg::result_t result_next;

  always_comb begin
    d = a3 - cfg.blk_log2;
    fat_bytes = 64'(fat_off3) << a3;
    root_blk = 64'(root_off3) << d;
    data_blk = 64'(data_off3) << d;
    dir_bytes = 44'(root_secs3) << a3;
    csize = 24'd1 << csz3;
    cbs = csz3 - {1'b0, cfg.blk_log2};
    result_next = '0;
    if (ok3) begin
      result_next.valid_res = 1'b1;
      if (fat32_3) begin
        result_next.fat_type = fbsg_pkg::FAT_TYPE_32;
      end else if (clusters3 >= fbsg_pkg::FAT16_MIN_CLUSTERS) begin
        result_next.fat_type = fbsg_pkg::FAT_TYPE_16;
      end else begin
        result_next.fat_type = fbsg_pkg::FAT_TYPE_12;
      end
      result_next.fat_byte_offset = fat_bytes[47:0];
      if (!fat32_3) begin
        result_next.root_dir_blk = root_blk[47:0];
        result_next.root_bytes = dir_bytes[21:0];
      end
      result_next.data_start_blk = data_blk[47:0];
      result_next.clus_blk_log2 = cbs[3:0];
      result_next.cluster_bytes = csize[12:0];
      result_next.data_cluster_count = clusters3;
      result_next.root_clus = rclus3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
`default_nettype wire

[design/fat_boot_sector_geometry.sv]
// Top level of the FAT boot sector geometry checker.
//
// A boot sector item is offered on sector with start high; it is taken at
// every rising edge where start is high and busy is low. The block is fully
// pipelined, so busy is high only during reset and one item can be taken in
// every cycle.
// Each item yields one result on result, marked by done for one cycle,
// once it has passed through the four register stages. Results leave in
// the order the items came in.
// The receiver cannot stall; the block never holds a result back.
// The pipeline has four register stages: field checks with the FAT size
// products, region offsets with the device size check, the data area check
// with the cluster count, and result formatting.
// The APB port holds the device block shift (address 0x0) and the device
// block count (address 0x8). The user must change them only while no item
// is in flight; the block does not enforce this. Reset empties the pipeline
// and sets the shift to 9 and the count to 0.
`timescale 1ns / 1ps
`default_nettype none
module fat_boot_sector_geometry (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire fbsg_pkg::sector_t    sector,
  output logic                      done,
  output fbsg_pkg::result_t         result,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [63:0]          pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  fbsg_pkg::cfg_t   cfg;
  fbsg_pkg::check_t chk;
  logic             chk_valid;

  assign busy = rst;

  fbsg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbsg_check u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .sector    (sector),
    .cfg       (cfg),
    .out_valid (chk_valid),
    .chk       (chk)
  );

  fbsg_place u_place (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chk_valid),
    .chk      (chk),
    .cfg      (cfg),
    .done     (done),
    .result   (result)
  );

endmodule
`default_nettype wire

[design/fbsg_checker.sv]
// Port-level checker for the FAT boot sector geometry checker, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module fbsg_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire fbsg_pkg::result_t    result
);

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("An accepted item gave no result after four cycles.");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("A result appeared without an item four cycles before.");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.valid_res) |->
      (result.fat_byte_offset == '0 && result.data_start_blk == '0 &&
       result.cluster_bytes == '0 && result.root_clus == '0))
    else $error("An invalid result carries nonzero fields.");

  a_valid_geometry: assert property (@(posedge clk) disable iff (rst)
    (done && result.valid_res) |->
      (result.cluster_bytes != '0 && result.fat_type != 2'd3))
    else $error("A valid result has an impossible geometry.");

endmodule

bind fat_boot_sector_geometry fbsg_checker u_fbsg_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

[bench/fat_boot_sector_geometry_tb.sv]
// Testbench that checks the FAT boot sector geometry checker against a built-in predictor.
`timescale 1ns / 1ps
module fat_boot_sector_geometry_tb;

  localparam logic [3:0] ADDR_LOG2 = {fbsg_pkg::REG_BLK_LOG2, 3'b000};
  localparam logic [3:0] ADDR_COUNT = {fbsg_pkg::REG_BLOCK_COUNT, 3'b000};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  fbsg_pkg::sector_t sector = '0;
  logic done;
  fbsg_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  fat_boot_sector_geometry u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sector(sector),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  logic [3:0] blk_shift;
  logic [47:0] blk_count;
  fbsg_pkg::result_t geometry_q[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned valid_seen = 0;
  int unsigned idle_pct = 0;

  function automatic fbsg_pkg::result_t predict_geometry(fbsg_pkg::sector_t s);
    fbsg_pkg::result_t r;
    logic [63:0] bsize, csize, sectors, fat_len, fat_off, root_off, root_secs;
    logic [63:0] data_off, clusters, blocks, bps, spc, idx;
    logic fat32;
    int lb;
    r = '0;
    bps = s.bytes_per_sector;
    spc = s.sectors_per_cluster;
    bsize = 64'd1 << blk_shift;
    fat32 = (s.fat_sectors_short == 0);
    if (s.signature != fbsg_pkg::SECTOR_MAGIC || bps == 0 || spc == 0 ||
        s.reserved_sectors == 0 || s.fat_copies == 0 || bps < bsize) return r;
    csize = bps * spc;
    if ((csize & (csize - 1)) != 0 || csize > fbsg_pkg::PAGE_BYTES) return r;
    sectors = (s.total_sectors_short != 0) ? 64'(s.total_sectors_short)
                                           : 64'(s.total_sectors_long);
    if (sectors == 0) return r;
    blocks = (sectors * bps - 1 + (bsize - 1)) >> blk_shift;
    if (blocks > blk_count) return r;
    fat_len = fat32 ? 64'(s.fat_sectors_long) : 64'(s.fat_sectors_short);
    if (fat_len == 0) return r;
    fat_off = s.reserved_sectors;
    root_off = fat_off + s.fat_copies * fat_len;
    root_secs = (64'(s.root_entry_count) * 32 + (bps - 1)) / bps;
    data_off = root_off + root_secs;
    if ((fat32 && root_secs != 0) || data_off >= sectors) return r;
    clusters = (sectors - data_off) / spc;
    if (fat32 && s.mirror_flags[fbsg_pkg::MIRROR_BIT]) begin
      idx = s.mirror_flags[3:0];
      if (idx >= s.fat_copies) return r;
      fat_off += idx * fat_len;
    end
    lb = 0;
    for (int i = 15; i >= 0; i--) begin
      if (csize[i]) lb = i;
    end
    r.valid_res = 1'b1;
    r.fat_type = fat32 ? fbsg_pkg::FAT_TYPE_32 :
                 (clusters >= fbsg_pkg::FAT16_MIN_CLUSTERS ? fbsg_pkg::FAT_TYPE_16
                                                          : fbsg_pkg::FAT_TYPE_12);
    r.fat_byte_offset = 48'(fat_off * bps);
    if (!fat32) begin
      r.root_dir_blk = 48'((root_off * bps) >> blk_shift);
      r.root_bytes = 22'(root_secs * bps);
    end
    r.data_start_blk = 48'((data_off * bps) >> blk_shift);
    r.clus_blk_log2 = 4'(lb - blk_shift);
    r.cluster_bytes = 13'(csize);
    r.data_cluster_count = 32'(clusters);
    r.root_clus = fat32 ? s.root_start_cluster : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, fbsg_pkg::result_t exp_r,
                                 fbsg_pkg::result_t act_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch (%s): expected %p", what, exp_r);
      $display("                actual   %p", act_r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (result.valid_res) valid_seen++;
      if (geometry_q.size() == 0) begin
        report_mismatch("no item waiting", '0, result);
      end else if (geometry_q[0] !== result) begin
        report_mismatch("field", geometry_q[0], result);
        void'(geometry_q.pop_front());
      end else begin
        void'(geometry_q.pop_front());
      end
    end
  end

  task automatic write_reg(logic [3:0] addr, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LOG2) blk_shift = data[3:0];
    else if (addr == ADDR_COUNT) blk_count = data[47:0];
  endtask

  task automatic set_device(logic [3:0] shift, logic [47:0] count);
    write_reg(ADDR_LOG2, 64'(shift));
    write_reg(ADDR_COUNT, 64'(count));
  endtask

  task automatic drain_pipe();
    while (geometry_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sends one item; a held start is never dropped and raised in one step.
  task automatic send_item(fbsg_pkg::sector_t s, fbsg_pkg::result_t exp_r, bit use_exp);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sector <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    geometry_q.push_back(use_exp ? exp_r : predict_geometry(s));
    items_sent++;
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fbsg_pkg::sector_t good_sector(bit fat32);
    fbsg_pkg::sector_t s;
    int sh;
    s = '0;
    s.signature = fbsg_pkg::SECTOR_MAGIC;
    sh = $urandom_range(12, (blk_shift > 12) ? 12 : blk_shift);
    s.bytes_per_sector = 16'(1) << sh;
    s.sectors_per_cluster = 8'(1) << $urandom_range(12 - sh > 7 ? 7 : 12 - sh, 0);
    if ($urandom_range(9) == 0) s.sectors_per_cluster = 8'($urandom);
    s.reserved_sectors = 16'($urandom_range(40, 1));
    s.fat_copies = 8'($urandom_range(3, 1));
    if (fat32) begin
      s.fat_sectors_long = $urandom_range(300, 1);
      s.total_sectors_long = $urandom_range(2000000, 1000);
      s.mirror_flags = 16'($urandom);
      if ($urandom_range(1)) s.mirror_flags[3:0] = 4'($urandom_range(3));
      s.root_start_cluster = $urandom;
    end else begin
      s.fat_sectors_short = 16'($urandom_range(64, 1));
      s.root_entry_count = 16'($urandom_range(1024));
      if ($urandom_range(1)) s.total_sectors_short = 16'($urandom_range(65535, 100));
      else s.total_sectors_long = $urandom_range(200000, 100);
      s.mirror_flags = 16'($urandom);
      s.root_start_cluster = $urandom;
    end
    case ($urandom_range(15))
      0: s.signature ^= 16'(1) << $urandom_range(15);
      1: s.bytes_per_sector = 16'($urandom);
      2: s.reserved_sectors = '0;
      3: s.fat_copies = '0;
      4: s.root_entry_count = 16'($urandom);
      5: s.total_sectors_long = $urandom;
      6: s.fat_sectors_long = $urandom;
      default: ;
    endcase
    return s;
  endfunction

  typedef struct {
    fbsg_pkg::sector_t s;
    bit typed;
    fbsg_pkg::result_t r;
  } row_t;

  row_t rows[$];

  function automatic fbsg_pkg::sector_t fat16_base();
    fbsg_pkg::sector_t s;
    s = '0;
    s.signature = fbsg_pkg::SECTOR_MAGIC;
    s.bytes_per_sector = 16'd512;
    s.sectors_per_cluster = 8'd4;
    s.reserved_sectors = 16'd1;
    s.fat_copies = 8'd2;
    s.root_entry_count = 16'd512;
    s.total_sectors_short = 16'd40000;
    s.fat_sectors_short = 16'd40;
    return s;
  endfunction

  task automatic build_rows();
    fbsg_pkg::sector_t s;
    row_t rw;
    rw.typed = 1'b1;
    rw.r = '0;
    rw.s = '0;
    rows.push_back(rw);
    rw.s = '1;
    rows.push_back(rw);
    s = fat16_base(); s.signature = 16'h55aa; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.bytes_per_sector = '0; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.sectors_per_cluster = '0; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.reserved_sectors = '0; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.fat_copies = '0; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.bytes_per_sector = 16'd256; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.sectors_per_cluster = 8'd3; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.sectors_per_cluster = 8'd16; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.total_sectors_short = '0; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.total_sectors_short = 16'd7; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.fat_sectors_short = '0; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.fat_sectors_short = '0; s.fat_sectors_long = 32'd10;
    rw.s = s; rows.push_back(rw);
    rw.typed = 1'b0;
    rw.s = fat16_base(); rows.push_back(rw);
    s = fat16_base(); s.total_sectors_short = 16'd2000; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.total_sectors_short = '0; s.total_sectors_long = 32'd60000;
    rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.fat_sectors_short = '0; s.root_entry_count = '0;
    s.fat_sectors_long = 32'd100; s.mirror_flags = 16'h0081; s.root_start_cluster = '1;
    rw.s = s; rows.push_back(rw);
    s.mirror_flags = 16'h0082; rw.s = s; rows.push_back(rw);
    s.mirror_flags = 16'hff7f; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.bytes_per_sector = 16'd4096; s.sectors_per_cluster = 8'd1;
    s.total_sectors_short = 16'd5000; rw.s = s; rows.push_back(rw);
    s = fat16_base(); s.reserved_sectors = 16'hffff; s.total_sectors_short = 16'hffff;
    rw.s = s; rows.push_back(rw);
  endtask

  initial begin
    int unsigned target;
    blk_shift = fbsg_pkg::BLK_LOG2_RESET;
    blk_count = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    build_rows();
    foreach (rows[i]) begin
      if (i == 14) begin
        end_burst();
        drain_pipe();
        set_device(4'd9, 48'd200000);
      end
      send_item(rows[i].s, rows[i].r, rows[i].typed);
    end
    end_burst();
    drain_pipe();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_device(4'd0, 48'hffff_ffff_ffff);
        1: set_device(4'd12, 48'd3000000);
        2: set_device(4'd9, 48'd0);
        3: set_device(4'($urandom_range(12)), 48'($urandom_range(4000000)));
        4: set_device(4'd15, 48'd100000);
        default: set_device(4'd9, 48'd5000000);
      endcase
      idle_pct = (ph < 2) ? 34 : ((ph < 4) ? 62 : 0);
      target = items_sent + 165;
      while (items_sent < target) begin
        if ($urandom_range(9) == 0) begin
          fbsg_pkg::sector_t s;
          s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
          if ($urandom_range(1)) s.signature = fbsg_pkg::SECTOR_MAGIC;
          send_item(s, '0, 1'b0);
        end else begin
          send_item(good_sector($urandom_range(1)), '0, 1'b0);
        end
      end
      end_burst();
      drain_pipe();
    end
    $display("Ran %0d boot sector items, %0d accepted as valid, over six device settings.",
             items_sent, valid_seen);
    if (mismatches == 0 && results_seen == items_sent && geometry_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results left waiting.", mismatches, geometry_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout.");
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
design/fbsg_pkg.sv
design/fbsg_cfg.sv
design/fbsg_check.sv
design/fbsg_place.sv
design/fat_boot_sector_geometry.sv
design/fbsg_checker.sv
bench/fat_boot_sector_geometry_tb.sv
